// File: rtl/uart_register_file_rx_fifo_defines.svh
// Assertion macros shared by the UART register block.
`ifndef UART_REGISTER_FILE_RX_FIFO_DEFINES_SVH
`define UART_REGISTER_FILE_RX_FIFO_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define URF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define URF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/urf_pkg.sv
// Types and constants for the UART register block.
package urf_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;

  localparam logic [4:0] IDX_IRQ     = 5'd0;
  localparam logic [4:0] IDX_ENABLES = 5'd1;
  localparam logic [4:0] IDX_IO      = 5'd16;
  localparam logic [4:0] IDX_IER     = 5'd17;
  localparam logic [4:0] IDX_IIR     = 5'd18;
  localparam logic [4:0] IDX_LCR     = 5'd19;
  localparam logic [4:0] IDX_MCR     = 5'd20;
  localparam logic [4:0] IDX_LSR     = 5'd21;
  localparam logic [4:0] IDX_MSR     = 5'd22;
  localparam logic [4:0] IDX_SCRATCH = 5'd23;
  localparam logic [4:0] IDX_CNTL    = 5'd24;
  localparam logic [4:0] IDX_STAT    = 5'd25;
  localparam logic [4:0] IDX_BAUD    = 5'd26;

  localparam logic [7:0] IIR_BASE   = 8'hC0;
  localparam logic [7:0] LSR_VALUE  = 8'h40;
  localparam logic [7:0] CNTL_RESET = 8'hC3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  word_index;
    logic [31:0] wr_data;
    logic [7:0]  rx_byte;
  } urf_in_t;

  typedef struct packed {
    logic [31:0] rd_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        bus_error;
    logic        rx_accepted;
    logic        rx_dropped;
    logic        irq;
  } urf_out_t;

  // Result of the register stage; pop marks that rd_data comes from the FIFO memory.
  typedef struct packed {
    urf_out_t res;
    logic     pop;
  } urf_stage_t;

endpackage

// File: rtl/uart_register_file_rx_fifo.sv
// Top level of the UART register block with RX byte FIFO.
//
//  channel | signals                 | direction | item
//  --------+-------------------------+-----------+--------------------------------
//  req     | req_valid, req_stall    | in        | read, write or received byte
//  rsp     | rsp_valid, rsp_stall    | out       | read data, tx byte, status flags
//
// One item per cycle while rsp is not stalled; it passes the FIFO memory read,
// then the result register. The memory stage holds the item while the memory
// read is in flight; the result register parts the two sides.
// Reset clears registers, pointers and the per-entry valid bits at once: no
// clearing pass, unwritten FIFO entries read as zero.
// req_stall rises only when both the memory stage and the result register
// are full and rsp is stalled.
module uart_register_file_rx_fifo import urf_pkg::*; #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  urf_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output urf_out_t rsp
);

`include "uart_register_file_rx_fifo_defines.svh"

  localparam int AW = $clog2(FIFO_DEPTH);

  logic          accept;
  urf_stage_t    stage;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // memory stage: item waiting for its FIFO byte
  logic          p1_valid;
  urf_stage_t    p1;
  logic          out_free;
  logic          p1_move;
  urf_out_t      merged;

  assign out_free  = ~rsp_valid | ~rsp_stall;
  assign p1_move   = p1_valid & out_free;
  assign req_stall = p1_valid & ~out_free;
  assign accept    = req_valid & ~req_stall;

  urf_regs #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .AW         (AW)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .stage     (stage),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // Read data register only changes on a new pop, which is only accepted while the
  // memory stage is empty or in the cycle its previous item leaves it.
  urf_ram #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    merged = p1.res;
    if (p1.pop) begin
      merged.rd_data = {24'b0, ram_rdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1 <= stage;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      rsp <= merged;
    end
  end

  `URF_ASSERT_NEXT(a_accept_fills_stage, accept, p1_valid, "accepted item missing from memory stage")
  `URF_ASSERT_NEXT(a_stage_drains, p1_move, rsp_valid, "memory stage item not delivered")
  `URF_ASSERT_NOW(a_rx_flags_excl, rsp_valid, !(rsp.rx_accepted && rsp.rx_dropped), "rx byte both accepted and dropped")
  `URF_ASSERT_NOW(a_tx_clean, rsp_valid && rsp.tx_valid, rsp.rd_data == 32'd0 && !rsp.bus_error, "tx item carries read data or error")

endmodule

// File: rtl/urf_ram.sv
// RX FIFO byte memory, one write and one registered read port, valid bit per entry.
module urf_ram import urf_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [7:0]       rd_byte;
  logic             rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_byte <= mem[rd_addr];
    end
  end

  // Never-written entries read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_byte : 8'h00;

endmodule

// File: rtl/urf_regs.sv
// Register file, FIFO pointers and per-item result logic.
module urf_regs import urf_pkg::*; #(
  parameter int FIFO_DEPTH = 8,
  parameter int AW         = $clog2(FIFO_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  urf_in_t       req,
  output urf_stage_t    stage,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int PW = CW + 1;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [31:0]   enables, enables_next;
  logic          rx_int, rx_int_next;
  logic          tx_int, tx_int_next;
  logic          dlab, dlab_next;
  logic          brk, brk_next;
  logic          size, size_next;
  logic          rts, rts_next;
  logic [31:0]   scratch, scratch_next;
  logic [7:0]    cntl, cntl_next;
  logic [15:0]   baud, baud_next;
  logic          level, level_next;
  logic          pending, pending_next;

  logic          empty, full;
  logic [PW-1:0] tail_sum, tail;
  logic          wr_req, rd_req;

  assign empty    = (count == '0);
  assign full     = (count == CW'(FIFO_DEPTH));
  assign tail_sum = PW'(head) + PW'(count);
  assign tail     = (tail_sum >= PW'(FIFO_DEPTH)) ? tail_sum - PW'(FIFO_DEPTH) : tail_sum;

  always_comb begin
    head_next    = head;
    count_next   = count;
    enables_next = enables;
    rx_int_next  = rx_int;
    tx_int_next  = tx_int;
    dlab_next    = dlab;
    brk_next     = brk;
    size_next    = size;
    rts_next     = rts;
    scratch_next = scratch;
    cntl_next    = cntl;
    baud_next    = baud;
    level_next   = level;
    pending_next = pending;
    stage        = '0;
    wr_req       = 1'b0;
    rd_req       = 1'b0;

    case (req.cmd)
      CMD_READ: begin
        case (req.word_index)
          IDX_IRQ:     stage.res.rd_data = {31'b0, pending};
          IDX_ENABLES: stage.res.rd_data = enables;
          IDX_IO: begin
            if (dlab) begin
              stage.res.rd_data = {24'b0, baud[7:0]};
            end else begin
              // Byte at head comes from memory next cycle; empty FIFO is not popped.
              stage.pop = 1'b1;
              rd_req    = 1'b1;
              if (!empty) begin
                count_next = count - 1'b1;
                head_next  = (head == AW'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
                if (count == CW'(1)) begin
                  level_next = 1'b0;
                end
              end
            end
          end
          IDX_IER: begin
            if (dlab) stage.res.rd_data = {24'b0, baud[15:8]};
            else      stage.res.rd_data = {29'b0, rx_int, tx_int, rx_int};
          end
          IDX_IIR:     stage.res.rd_data = {24'b0, IIR_BASE | {7'b0, ~pending}};
          IDX_LCR:     stage.res.rd_data = {24'b0, dlab, brk, 5'b0, size};
          IDX_MCR:     stage.res.rd_data = {30'b0, rts, 1'b0};
          IDX_LSR:     stage.res.rd_data = {24'b0, LSR_VALUE};
          IDX_MSR:     stage.res.rd_data = '0;
          IDX_SCRATCH: stage.res.rd_data = scratch;
          IDX_CNTL:    stage.res.rd_data = {24'b0, cntl};
          IDX_STAT: begin
            stage.res.rd_data = {22'b0, empty, empty, 1'b1, rts, full, 1'b0, 1'b1,
                                 1'b0, ~full, ~empty};
          end
          IDX_BAUD:    stage.res.rd_data = {16'b0, baud};
          default:     stage.res.bus_error = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        case (req.word_index)
          IDX_ENABLES: enables_next = req.wr_data;
          IDX_IO: begin
            if (dlab) begin
              baud_next[7:0] = req.wr_data[7:0];
            end else begin
              stage.res.tx_valid = 1'b1;
              stage.res.tx_byte  = req.wr_data[7:0];
            end
          end
          IDX_IER: begin
            if (dlab) begin
              baud_next[15:8] = req.wr_data[7:0];
            end else begin
              tx_int_next = req.wr_data[1];
              rx_int_next = req.wr_data[0] & req.wr_data[2];
            end
          end
          IDX_IIR: begin
            // FIFO flush; level flag stays as it was
            if (req.wr_data[2:1] != 2'b00) begin
              count_next = '0;
              head_next  = '0;
            end
          end
          IDX_LCR: begin
            dlab_next = req.wr_data[7];
            brk_next  = req.wr_data[6];
            size_next = req.wr_data[0];
          end
          IDX_MCR:     rts_next     = req.wr_data[1];
          IDX_SCRATCH: scratch_next = req.wr_data;
          IDX_CNTL:    cntl_next    = req.wr_data[7:0];
          IDX_BAUD:    baud_next    = req.wr_data[15:0];
          default:     stage.res.bus_error = 1'b1;
        endcase
      end
      CMD_RX: begin
        if ((enables != '0) && rx_int) begin
          if (full) begin
            stage.res.rx_dropped = 1'b1;
          end else begin
            wr_req                = 1'b1;
            count_next            = count + 1'b1;
            level_next            = 1'b1;
            pending_next          = 1'b1;
            stage.res.rx_accepted = 1'b1;
          end
        end
      end
      default: ;
    endcase

    stage.res.irq = level_next & pending_next;
  end

  assign ram_we    = accept & wr_req;
  assign ram_waddr = tail[AW-1:0];
  assign ram_wdata = req.rx_byte;
  assign ram_re    = accept & rd_req;
  assign ram_raddr = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      enables <= '0;
      rx_int  <= 1'b0;
      tx_int  <= 1'b0;
      dlab    <= 1'b0;
      brk     <= 1'b0;
      size    <= 1'b0;
      rts     <= 1'b0;
      scratch <= '0;
      cntl    <= CNTL_RESET;
      baud    <= '0;
      level   <= 1'b0;
      pending <= 1'b0;
    end else if (accept) begin
      head    <= head_next;
      count   <= count_next;
      enables <= enables_next;
      rx_int  <= rx_int_next;
      tx_int  <= tx_int_next;
      dlab    <= dlab_next;
      brk     <= brk_next;
      size    <= size_next;
      rts     <= rts_next;
      scratch <= scratch_next;
      cntl    <= cntl_next;
      baud    <= baud_next;
      level   <= level_next;
      pending <= pending_next;
    end
  end

endmodule

// File: dv/uart_register_file_rx_fifo_tb.sv
// Self-checking testbench for the UART register block with RX byte FIFO.
module uart_register_file_rx_fifo_tb;
  import urf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RX_DEPTH     = 8;
  localparam int RESET_CYCLES = 12;
  localparam int N_ITEMS      = 1150;
  localparam int HOLD_AT      = 300;    // accepted items before the long receiver hold-off
  localparam int HOLD_CYCLES  = 120;
  localparam int QUIET_LO     = 600;    // window of accepted items with no idling at all
  localparam int QUIET_HI     = 800;
  localparam int PAUSE_AT     = 950;    // sender stops here until every result is back
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_SHOWN    = 10;

  // Every index that decodes to a register.
  localparam logic [4:0] REG_IDX [13] = '{IDX_IRQ, IDX_ENABLES, IDX_IO, IDX_IER, IDX_IIR,
                                          IDX_LCR, IDX_MCR, IDX_LSR, IDX_MSR, IDX_SCRATCH,
                                          IDX_CNTL, IDX_STAT, IDX_BAUD};

  // Register-file mirror plus the queue of results still owed by the block.
  class uart_reg_scoreboard;
    logic [7:0]  rx_mem [RX_DEPTH];
    logic [2:0]  rd_ptr;
    logic [3:0]  fill;
    logic [31:0] enables;
    logic        rx_ie, tx_ie;
    logic        dlab, brk, wsize;
    logic        rts;
    logic [31:0] scratch;
    logic [7:0]  cntl;
    logic [15:0] divisor;
    logic        level, sticky;
    urf_out_t    rsp_due_q[$];
    int          mismatches;

    function new();
      foreach (rx_mem[k]) rx_mem[k] = 8'h00;
      rd_ptr     = '0;
      fill       = '0;
      enables    = '0;
      rx_ie      = 1'b0;
      tx_ie      = 1'b0;
      dlab       = 1'b0;
      brk        = 1'b0;
      wsize      = 1'b0;
      rts        = 1'b0;
      scratch    = '0;
      cntl       = CNTL_RESET;
      divisor    = '0;
      level      = 1'b0;
      sticky     = 1'b0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return rsp_due_q.size();
    endfunction

    // Advance the mirror by one accepted item and queue the result it owes.
    function void note_request(urf_in_t it);
      urf_out_t   r;
      logic [2:0] wr_slot;
      logic       empty, full;
      r     = '0;
      empty = (fill == 0);
      full  = (fill >= RX_DEPTH);
      case (it.cmd)
        CMD_READ: begin
          case (it.word_index)
            IDX_IRQ:     r.rd_data = {31'd0, sticky};
            IDX_ENABLES: r.rd_data = enables;
            IDX_IO: begin
              if (dlab) begin
                r.rd_data = {24'd0, divisor[7:0]};
              end else begin
                // empty FIFO still returns the slot at the read pointer
                r.rd_data = {24'd0, rx_mem[rd_ptr]};
                if (fill != 0) begin
                  fill   = fill - 4'd1;
                  rd_ptr = rd_ptr + 3'd1;
                  if (fill == 0) level = 1'b0;
                end
              end
            end
            IDX_IER: begin
              if (dlab) r.rd_data = {24'd0, divisor[15:8]};
              else      r.rd_data = {29'd0, rx_ie, tx_ie, rx_ie};
            end
            IDX_IIR:     r.rd_data = {24'd0, IIR_BASE | {7'd0, ~sticky}};
            IDX_LCR:     r.rd_data = {24'd0, dlab, brk, 5'd0, wsize};
            IDX_MCR:     r.rd_data = {30'd0, rts, 1'b0};
            IDX_LSR:     r.rd_data = {24'd0, LSR_VALUE};
            IDX_MSR:     r.rd_data = '0;
            IDX_SCRATCH: r.rd_data = scratch;
            IDX_CNTL:    r.rd_data = {24'd0, cntl};
            IDX_STAT:    r.rd_data = {22'd0, empty, empty, 1'b1, rts, full, 1'b0, 1'b1, 1'b0,
                                      ~full, ~empty};
            IDX_BAUD:    r.rd_data = {16'd0, divisor};
            default:     r.bus_error = 1'b1;
          endcase
        end
        CMD_WRITE: begin
          case (it.word_index)
            IDX_ENABLES: enables = it.wr_data;
            IDX_IO: begin
              if (dlab) begin
                divisor[7:0] = it.wr_data[7:0];
              end else begin
                r.tx_valid = 1'b1;
                r.tx_byte  = it.wr_data[7:0];
              end
            end
            IDX_IER: begin
              if (dlab) begin
                divisor[15:8] = it.wr_data[7:0];
              end else begin
                tx_ie = it.wr_data[1];
                rx_ie = it.wr_data[0] & it.wr_data[2];
              end
            end
            IDX_IIR: begin
              // flush leaves the level flag alone
              if (it.wr_data[2:1] != 2'b00) begin
                fill   = '0;
                rd_ptr = '0;
              end
            end
            IDX_LCR: begin
              dlab  = it.wr_data[7];
              brk   = it.wr_data[6];
              wsize = it.wr_data[0];
            end
            IDX_MCR:     rts = it.wr_data[1];
            IDX_SCRATCH: scratch = it.wr_data;
            IDX_CNTL:    cntl = it.wr_data[7:0];
            IDX_BAUD:    divisor = it.wr_data[15:0];
            default:     r.bus_error = 1'b1;   // read-only or unknown
          endcase
        end
        CMD_RX: begin
          if (enables != 0 && rx_ie) begin
            if (full) begin
              r.rx_dropped = 1'b1;
            end else begin
              wr_slot         = rd_ptr + fill[2:0];
              rx_mem[wr_slot] = it.rx_byte;
              fill            = fill + 4'd1;
              level           = 1'b1;
              sticky          = 1'b1;
              r.rx_accepted   = 1'b1;
            end
          end
        end
        default: ;   // reserved command does nothing
      endcase
      r.irq = level & sticky;
      rsp_due_q.push_back(r);
    endfunction

    function void check_response(urf_out_t got);
      urf_out_t want;
      if (rsp_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result rd=%h tx=%b/%h err=%b acc=%b drop=%b irq=%b",
                   got.rd_data, got.tx_valid, got.tx_byte, got.bus_error,
                   got.rx_accepted, got.rx_dropped, got.irq);
        return;
      end
      want = rsp_due_q.pop_front();
      if (got.rd_data !== want.rd_data || got.tx_valid !== want.tx_valid ||
          got.tx_byte !== want.tx_byte || got.bus_error !== want.bus_error ||
          got.rx_accepted !== want.rx_accepted || got.rx_dropped !== want.rx_dropped ||
          got.irq !== want.irq) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("mismatch exp rd=%h tx=%b/%h err=%b acc=%b drop=%b irq=%b",
                   want.rd_data, want.tx_valid, want.tx_byte, want.bus_error,
                   want.rx_accepted, want.rx_dropped, want.irq);
          $display("         got rd=%h tx=%b/%h err=%b acc=%b drop=%b irq=%b",
                   got.rd_data, got.tx_valid, got.tx_byte, got.bus_error,
                   got.rx_accepted, got.rx_dropped, got.irq);
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  urf_in_t  req;
  logic     rsp_valid;
  logic     rsp_stall;
  urf_out_t rsp;

  uart_reg_scoreboard sb = new();
  int n_accepted = 0;   // items taken by the block, drives the hold-off and quiet window
  int n_issued   = 0;   // items handed to the driver
  int cycles     = 0;

  uart_register_file_rx_fifo u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Neither side idles while the accepted count is inside this window.
  function automatic bit quiet_window();
    return n_accepted >= QUIET_LO && n_accepted < QUIET_HI;
  endfunction

  // Both handshakes are observed at the rising edge, with values set at the last falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        sb.note_request(req);
        n_accepted++;
      end
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("uart_register_file_rx_fifo_tb NOT OK");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off so the block backs up into req_stall,
  // and no stalls inside the quiet window.
  initial begin : rsp_side
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (quiet_window()) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 23);
      end
    end
  end

  function automatic urf_in_t mk_item(logic [1:0] c, logic [4:0] i, logic [31:0] d,
                                      logic [7:0] b);
    urf_in_t it;
    it.cmd        = c;
    it.word_index = i;
    it.wr_data    = d;
    it.rx_byte    = b;
    return it;
  endfunction

  // Random access to a decoded register; writes are biased so the receive path stays
  // enabled and DLAB stays clear most of the time.
  function automatic urf_in_t rand_reg_access();
    logic [4:0]  idx;
    logic [31:0] d;
    idx = REG_IDX[4'($urandom_range(12))];
    d   = $urandom;
    if ($urandom_range(1) == 0) return mk_item(CMD_READ, idx, d, 8'($urandom_range(255)));
    case (idx)
      IDX_ENABLES: if ($urandom_range(9) == 0) d = '0; else if (d == 0) d = 32'd1;
      IDX_IER:     if ($urandom_range(3) != 0) d = d | 32'h5;
      IDX_LCR:     if ($urandom_range(4) != 0) d = d & ~32'h80;
      default: ;
    endcase
    return mk_item(CMD_WRITE, idx, d, 8'($urandom_range(255)));
  endfunction

  // All driver tasks start and end at a falling edge; valid is held high between
  // back-to-back items, so each signal is assigned at most once per edge.
  task automatic issue(urf_in_t it);
    while (!quiet_window() && $urandom_range(99) < 23) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    n_issued++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic run_directed();
    issue(mk_item(CMD_READ,  IDX_STAT,    32'h0, 8'h00));   // empty, not full
    issue(mk_item(CMD_READ,  IDX_CNTL,    32'h0, 8'h00));   // reset value
    issue(mk_item(CMD_READ,  IDX_IIR,     32'h0, 8'h00));   // nothing pending yet
    issue(mk_item(CMD_READ,  IDX_IO,      32'h0, 8'h00));   // pop of an empty FIFO
    issue(mk_item(CMD_RX,    IDX_IRQ,     32'h0, 8'h00));   // receive path still off
    issue(mk_item(CMD_WRITE, IDX_ENABLES, 32'hFFFF_FFFF, 8'h00));
    issue(mk_item(CMD_WRITE, IDX_IER,     32'h0000_0007, 8'h00));
    issue(mk_item(CMD_RX,    IDX_IRQ,     32'h0, 8'hFF));   // accepted, pending sticks
    issue(mk_item(CMD_READ,  IDX_IRQ,     32'h0, 8'h00));
    issue(mk_item(CMD_READ,  IDX_IO,      32'h0, 8'h00));   // last byte clears the level
    issue(mk_item(CMD_READ,  IDX_IO,      32'h0, 8'h00));   // empty again, stale slot
    issue(mk_item(CMD_WRITE, IDX_IIR,     32'h0000_0006, 8'h00));   // flush
    issue(mk_item(CMD_WRITE, IDX_LCR,     32'hFFFF_FFFF, 8'h00));   // DLAB, break, size
    issue(mk_item(CMD_WRITE, IDX_IO,      32'hFFFF_FFAB, 8'h00));   // divisor low byte
    issue(mk_item(CMD_WRITE, IDX_IER,     32'hFFFF_FFCD, 8'h00));   // divisor high byte
    issue(mk_item(CMD_READ,  IDX_IER,     32'h0, 8'h00));
    issue(mk_item(CMD_READ,  IDX_LCR,     32'h0, 8'h00));
    issue(mk_item(CMD_WRITE, IDX_LCR,     32'h0, 8'h00));
    issue(mk_item(CMD_WRITE, IDX_IO,      32'h0000_005A, 8'h00));   // transmit
    issue(mk_item(CMD_WRITE, IDX_BAUD,    32'hFFFF_FFFF, 8'h00));   // only 16 bits kept
    issue(mk_item(CMD_WRITE, IDX_CNTL,    32'h0, 8'h00));
    issue(mk_item(CMD_WRITE, IDX_STAT,    32'hFFFF_FFFF, 8'h00));   // read-only
    issue(mk_item(CMD_READ,  5'd31,       32'h0, 8'h00));           // unknown index
    issue(mk_item(2'd3,      5'd31,       32'hFFFF_FFFF, 8'hFF));   // reserved command
    issue(mk_item(CMD_WRITE, IDX_SCRATCH, 32'hFFFF_FFFF, 8'h00));
    issue(mk_item(CMD_READ,  IDX_SCRATCH, 32'h0, 8'h00));
  endtask

  task automatic run_random();
    int  sel;
    bit  paused;
    logic [31:0] d;
    paused = 1'b0;
    while (n_issued < N_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        // burst of received bytes, at times long enough to fill and overflow the FIFO
        repeat ($urandom_range(1, 12))
          issue(mk_item(CMD_RX, 5'($urandom_range(31)), $urandom,
                        8'($urandom_range(255))));
      end else if (sel < 52) begin
        repeat ($urandom_range(1, 10))
          issue(mk_item(CMD_READ, IDX_IO, $urandom, 8'($urandom_range(255))));
      end else if (sel < 72) begin
        repeat ($urandom_range(1, 4)) issue(rand_reg_access());
      end else if (sel < 77) begin
        issue(mk_item(CMD_WRITE, IDX_IIR, $urandom, 8'($urandom_range(255))));
      end else if (sel < 82) begin
        // divisor-latch episode, always closed by clearing DLAB
        issue(mk_item(CMD_WRITE, IDX_LCR, $urandom | 32'h80, 8'($urandom_range(255))));
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(5))
            0: issue(mk_item(CMD_READ,  IDX_IO,   $urandom, 8'($urandom_range(255))));
            1: issue(mk_item(CMD_WRITE, IDX_IO,   $urandom, 8'($urandom_range(255))));
            2: issue(mk_item(CMD_READ,  IDX_IER,  $urandom, 8'($urandom_range(255))));
            3: issue(mk_item(CMD_WRITE, IDX_IER,  $urandom, 8'($urandom_range(255))));
            4: issue(mk_item(CMD_READ,  IDX_BAUD, $urandom, 8'($urandom_range(255))));
            default: issue(mk_item(CMD_READ, IDX_LCR, $urandom, 8'($urandom_range(255))));
          endcase
        end
        issue(mk_item(CMD_WRITE, IDX_LCR, $urandom & ~32'h80, 8'($urandom_range(255))));
      end else if (sel < 88) begin
        // turn the receive path back on (now and then off)
        d = $urandom;
        if ($urandom_range(9) == 0) d = '0; else if (d == 0) d = 32'd1;
        issue(mk_item(CMD_WRITE, IDX_ENABLES, d, 8'($urandom_range(255))));
        d = $urandom;
        if ($urandom_range(4) != 0) d = d | 32'h5;
        issue(mk_item(CMD_WRITE, IDX_IER, d, 8'($urandom_range(255))));
      end else begin
        // noise: any command, any index
        repeat ($urandom_range(1, 3))
          issue(mk_item(2'($urandom_range(3)), 5'($urandom_range(31)), $urandom,
                        8'($urandom_range(255))));
      end
      if (!paused && n_issued >= PAUSE_AT) begin
        paused = 1'b1;
        wait_drained();
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    wait_drained();
    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("uart_register_file_rx_fifo_tb OK");
    end else begin
      $display("uart_register_file_rx_fifo_tb NOT OK");
    end
    $finish;
  end

endmodule
